### sv/assert_macros.svh
// assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/bbfa_pkg.sv
// types and constants shared by the allocator modules
`default_nettype none

package bbfa_pkg;

  localparam int unsigned WORD_W = 32;

  // smallest effective memory size, also the size register reset value
  localparam logic [WORD_W-1:0] MIN_MEMORY     = 32'h0000_1000;
  localparam logic [WORD_W-1:0] MEM_SIZE_RESET = 32'h0000_1000;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LIVE1,
    S_FREE1,
    S_LIVE2,
    S_FREE2,
    S_TRIV,
    S_COMMIT
  } state_t;

  // flags accumulated by one table pass
  typedef struct packed {
    logic match_found;
    logic empty_found;
    logic best_found;
  } scan_flags_t;

  // status into the sequencer
  typedef struct packed {
    logic        acc;
    logic        is_free;
    logic        is_zero;
    logic        oversize;
    logic        bump_fit;
    logic        out_free;
    logic        scan_done;
    scan_flags_t flags;
  } ctrl_in_t;

  // commands out of the sequencer
  typedef struct packed {
    logic in_ready;
    logic scan_start;
    logic scan_live;
    logic scan_best;
    logic key_saved;
    logic key_bump;
    logic save;
    logic commit_go;
    logic triv_go;
  } ctrl_out_t;

endpackage

`default_nettype wire

### sv/bbfa_scan.sv
// table scan unit: one entry a cycle, match / first empty / best fit
`default_nettype none

module bbfa_scan import bbfa_pkg::*; #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IDX_W   = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              find_best,
  input  wire logic [WORD_W-1:0] key_addr,
  input  wire logic [WORD_W-1:0] key_size,
  output logic      [IDX_W-1:0]  rd_addr,
  input  wire logic              ent_vld,
  input  wire logic [WORD_W-1:0] ent_addr,
  input  wire logic [WORD_W-1:0] ent_size,
  output logic                   done,
  output scan_flags_t            flags,
  output logic      [IDX_W-1:0]  match_idx,
  output logic      [WORD_W-1:0] match_size,
  output logic      [IDX_W-1:0]  empty_idx,
  output logic      [IDX_W-1:0]  best_idx,
  output logic      [WORD_W-1:0] best_addr
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic              busy_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              dvld_r;
  logic              dlast_r;
  logic              done_r;
  logic [IDX_W-1:0]  didx_r;
  scan_flags_t       flags_r;
  scan_flags_t       flags_nxt;
  logic [IDX_W-1:0]  match_idx_r;
  logic [WORD_W-1:0] match_size_r;
  logic [IDX_W-1:0]  empty_idx_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [WORD_W-1:0] best_addr_r;
  logic [WORD_W-1:0] best_size_r;
  logic              take_match;
  logic              take_empty;
  logic              take_best;

  // read address sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      dvld_r  <= 1'b0;
      dlast_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      dvld_r  <= busy_r;
      dlast_r <= busy_r && (cnt_r == LAST_IDX);
      // done once the last entry has been folded into the results
      done_r  <= dvld_r && dlast_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_IDX) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= cnt_r;
  end

  assign rd_addr = cnt_r;
  assign done    = done_r;

  // compare the returned entry against the key and the current best
  always_comb begin
    take_match = dvld_r && ent_vld && (ent_addr == key_addr) && !flags_r.match_found;
    take_empty = dvld_r && !ent_vld && !flags_r.empty_found;
    take_best  = dvld_r && find_best && ent_vld && (ent_size >= key_size) &&
                 (!flags_r.best_found || (ent_size < best_size_r) ||
                  ((ent_size == best_size_r) && (ent_addr < best_addr_r)));
  end

  // next flags
  always_comb begin
    flags_nxt = flags_r;
    if (take_match) begin
      flags_nxt.match_found = 1'b1;
    end
    if (take_empty) begin
      flags_nxt.empty_found = 1'b1;
    end
    if (take_best) begin
      flags_nxt.best_found = 1'b1;
    end
  end

  // accumulated flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (start) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  // accumulated indexes and values
  always_ff @(posedge clk) begin
    if (take_match) begin
      match_idx_r  <= didx_r;
      match_size_r <= ent_size;
    end
    if (take_empty) begin
      empty_idx_r <= didx_r;
    end
    if (take_best) begin
      best_idx_r  <= didx_r;
      best_addr_r <= ent_addr;
      best_size_r <= ent_size;
    end
  end

  assign flags      = flags_r;
  assign match_idx  = match_idx_r;
  assign match_size = match_size_r;
  assign empty_idx  = empty_idx_r;
  assign best_idx   = best_idx_r;
  assign best_addr  = best_addr_r;

endmodule

`default_nettype wire

### sv/bbfa_ctrl.sv
// request sequencer: orders the table passes and the commit
`default_nettype none

module bbfa_ctrl import bbfa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ctrl_in_t ci,
  output ctrl_out_t     co
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ci.acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ci.is_free) begin
          state_nxt = S_LIVE1;
        end else if (ci.is_zero || ci.oversize) begin
          state_nxt = S_TRIV;
        end else if (ci.bump_fit) begin
          state_nxt = S_LIVE1;
        end else begin
          state_nxt = S_FREE1;
        end
      end
      S_LIVE1: begin
        if (ci.scan_done) begin
          if (!ci.is_free) begin
            state_nxt = S_COMMIT;
          end else if (ci.flags.match_found) begin
            state_nxt = S_FREE2;
          end else begin
            state_nxt = S_TRIV;
          end
        end
      end
      S_FREE1: begin
        if (ci.scan_done) begin
          state_nxt = ci.flags.best_found ? S_LIVE2 : S_TRIV;
        end
      end
      S_LIVE2, S_FREE2: begin
        if (ci.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_TRIV, S_COMMIT: begin
        if (ci.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    co            = '0;
    co.in_ready   = (state_r == S_IDLE);
    co.scan_start = (state_nxt != state_r) &&
                    (state_nxt inside {S_LIVE1, S_FREE1, S_LIVE2, S_FREE2});
    co.scan_live  = (state_r inside {S_LIVE1, S_LIVE2});
    co.scan_best  = (state_r == S_FREE1);
    co.key_saved  = (state_r == S_LIVE2);
    co.key_bump   = (state_r == S_LIVE1) && !ci.is_free;
    co.save       = ci.scan_done &&
                    (((state_r == S_LIVE1) && ci.is_free) || (state_r == S_FREE1));
    co.commit_go  = (state_r == S_COMMIT) && ci.out_free;
    co.triv_go    = (state_r == S_TRIV) && ci.out_free;
  end

endmodule

`default_nettype wire

### sv/bump_best_fit_allocator.sv
// allocator top level: tables, size register, request and result registers
//
//  channel | signals                                            | accepted when
//  --------+----------------------------------------------------+----------------------
//  in      | in_req_type, in_req_size, in_req_address           | in_valid && in_ready
//  out     | out_status, out_result_address, out_freed_size     | out_valid && out_ready
//  cfg     | cfg_wdata (memory size)                            | cfg_we
//
// each table pass is made by the one scan unit, which reads one table entry a cycle:
// no pass for a zero size or oversize allocate; one pass for a bump allocate, a free
// of an unknown address or a best-fit search that finds nothing; two for any other
// best-fit allocate or free.
// in_ready is high only while the sequencer is idle; a finished result sits in the
// output register and a new item may enter while it waits.
// the commit of the next item waits for the output register to be taken.
// rst_n is synchronous; the valid bits clear at once, table contents are not reset.
`default_nettype none

`include "assert_macros.svh"

module bump_best_fit_allocator import bbfa_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic [WORD_W-1:0] in_req_size,
  input  wire logic [WORD_W-1:0] in_req_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [1:0]        out_status,
  output logic      [WORD_W-1:0] out_result_address,
  output logic      [WORD_W-1:0] out_freed_size,
  input  wire logic              cfg_we,
  input  wire logic [WORD_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  ctrl_in_t          ci;
  ctrl_out_t         co;
  scan_flags_t       flags;

  logic [WORD_W-1:0] memory_size_r;
  logic [WORD_W-1:0] bump_offset_r;
  logic              req_type_r;
  logic [WORD_W-1:0] req_size_r;
  logic [WORD_W-1:0] req_addr_r;
  logic [IDX_W-1:0]  save_idx_r;
  logic [WORD_W-1:0] save_val_r;

  logic [2*WORD_W-1:0] live_mem_r [TABLE_ENTRIES];
  logic [2*WORD_W-1:0] free_mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] live_valid_r;
  logic [TABLE_ENTRIES-1:0] free_valid_r;
  logic [2*WORD_W-1:0] live_q_r;
  logic [2*WORD_W-1:0] free_q_r;
  logic                live_vq_r;
  logic                free_vq_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [WORD_W-1:0] out_result_address_r;
  logic [WORD_W-1:0] out_freed_size_r;

  logic [WORD_W-1:0] mem_eff;
  logic [WORD_W:0]   bump_sum;
  logic              acc;
  logic              out_free;
  logic [IDX_W-1:0]  rd_addr;
  logic              scan_done;
  logic [WORD_W-1:0] key_addr;
  logic              ent_vld;
  logic [2*WORD_W-1:0] ent;
  logic [IDX_W-1:0]  match_idx;
  logic [WORD_W-1:0] match_size;
  logic [IDX_W-1:0]  empty_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [WORD_W-1:0] best_addr;

  logic              slot_found;
  logic [IDX_W-1:0]  slot;
  logic              live_we;
  logic [IDX_W-1:0]  live_wa;
  logic [2*WORD_W-1:0] live_wd;
  logic              live_clr;
  logic              free_we;
  logic [IDX_W-1:0]  free_wa;
  logic [2*WORD_W-1:0] free_wd;
  logic              free_clr;
  logic              bump_adv;
  logic [1:0]        res_status;
  logic [WORD_W-1:0] res_addr;
  logic [WORD_W-1:0] res_fsize;

  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = co.in_ready;

  // effective size and the bump check
  assign mem_eff  = (memory_size_r < MIN_MEMORY) ? MIN_MEMORY : memory_size_r;
  assign bump_sum = {1'b0, bump_offset_r} + {1'b0, req_size_r};

  // sequencer status
  always_comb begin
    ci           = '0;
    ci.acc       = acc;
    ci.is_free   = (req_type_r == REQ_FREE);
    ci.is_zero   = (req_size_r == '0);
    ci.oversize  = (req_size_r > mem_eff);
    ci.bump_fit  = (bump_sum <= {1'b0, mem_eff});
    ci.out_free  = out_free;
    ci.scan_done = scan_done;
    ci.flags     = flags;
  end

  bbfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .ci    (ci),
    .co    (co)
  );

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_size_r <= MEM_SIZE_RESET;
    end else if (cfg_we) begin
      memory_size_r <= cfg_wdata;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (acc) begin
      req_type_r <= in_req_type;
      req_size_r <= in_req_size;
      req_addr_r <= in_req_address;
    end
  end

  // first pass result kept for the second pass and the commit
  always_ff @(posedge clk) begin
    if (co.save) begin
      save_idx_r <= co.scan_best ? best_idx : match_idx;
      save_val_r <= co.scan_best ? best_addr : match_size;
    end
  end

  // scan key
  always_comb begin
    if (co.key_saved) begin
      key_addr = save_val_r;
    end else if (co.key_bump) begin
      key_addr = bump_offset_r;
    end else begin
      key_addr = req_addr_r;
    end
  end

  // table read ports
  always_ff @(posedge clk) begin
    live_q_r  <= live_mem_r[rd_addr];
    free_q_r  <= free_mem_r[rd_addr];
    live_vq_r <= live_valid_r[rd_addr];
    free_vq_r <= free_valid_r[rd_addr];
  end

  assign ent_vld = co.scan_live ? live_vq_r : free_vq_r;
  assign ent     = co.scan_live ? live_q_r : free_q_r;

  bbfa_scan #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (co.scan_start),
    .find_best  (co.scan_best),
    .key_addr   (key_addr),
    .key_size   (req_size_r),
    .rd_addr    (rd_addr),
    .ent_vld    (ent_vld),
    .ent_addr   (ent[2*WORD_W-1:WORD_W]),
    .ent_size   (ent[WORD_W-1:0]),
    .done       (scan_done),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_size (match_size),
    .empty_idx  (empty_idx),
    .best_idx   (best_idx),
    .best_addr  (best_addr)
  );

  // commit: table updates and the result
  always_comb begin
    slot_found = flags.match_found || flags.empty_found;
    slot       = flags.match_found ? match_idx : empty_idx;
    live_we    = 1'b0;
    live_wa    = slot;
    live_wd    = {bump_offset_r, req_size_r};
    live_clr   = 1'b0;
    free_we    = 1'b0;
    free_wa    = slot;
    free_wd    = {req_addr_r, save_val_r};
    free_clr   = 1'b0;
    bump_adv   = 1'b0;
    res_status = STAT_OK;
    res_addr   = '0;
    res_fsize  = '0;
    if (co.triv_go) begin
      if (ci.is_free) begin
        res_status = STAT_UNKNOWN;
      end else if (ci.is_zero) begin
        res_status = STAT_OK;
      end else begin
        res_status = STAT_NOSPACE;
      end
    end else if (co.commit_go) begin
      if (!slot_found) begin
        res_status = STAT_FULL;
      end else if (ci.is_free) begin
        live_clr  = 1'b1;
        free_we   = 1'b1;
        res_fsize = save_val_r;
      end else if (ci.bump_fit) begin
        live_we  = 1'b1;
        bump_adv = 1'b1;
        res_addr = bump_offset_r;
      end else begin
        live_we  = 1'b1;
        live_wd  = {save_val_r, req_size_r};
        free_clr = 1'b1;
        res_addr = save_val_r;
      end
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem_r[live_wa] <= live_wd;
    end
    if (free_we) begin
      free_mem_r[free_wa] <= free_wd;
    end
  end

  // valid bits and bump offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_valid_r  <= '0;
      free_valid_r  <= '0;
      bump_offset_r <= '0;
    end else begin
      if (live_we) begin
        live_valid_r[live_wa] <= 1'b1;
      end
      if (live_clr) begin
        live_valid_r[save_idx_r] <= 1'b0;
      end
      if (free_we) begin
        free_valid_r[free_wa] <= 1'b1;
      end
      if (free_clr) begin
        free_valid_r[save_idx_r] <= 1'b0;
      end
      if (bump_adv) begin
        bump_offset_r <= bump_sum[WORD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (co.commit_go || co.triv_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (co.commit_go || co.triv_go) begin
      out_status_r         <= res_status;
      out_result_address_r <= res_addr;
      out_freed_size_r     <= res_fsize;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_result_address_r;
  assign out_freed_size     = out_freed_size_r;

  // checks
  `ASSERT_NEVER(a_one_result, co.commit_go && co.triv_go, "commit and trivial result together")
  `ASSERT_CLK(a_bump_only_on_commit, !bump_adv |=> $stable(bump_offset_r), "bump offset moved")
  `ASSERT_CLK(a_one_item_at_a_time, acc |=> !in_ready, "item accepted while busy")

endmodule

`default_nettype wire

### verif/bbfa_alloc_checker.sv
// allocator checker: tracks both tables and the size register, predicts each result and compares
`timescale 1ns / 100ps

module bbfa_alloc_checker import bbfa_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_req_type,
  input  logic [WORD_W-1:0] in_req_size,
  input  logic [WORD_W-1:0] in_req_address,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_status,
  input  logic [WORD_W-1:0] out_result_address,
  input  logic [WORD_W-1:0] out_freed_size,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] grant_addr;
    logic [WORD_W-1:0] freed_len;
  } alloc_result_t;

  // shadow of the size register, the bump offset and both tables
  logic [WORD_W-1:0] mem_size;
  logic [WORD_W-1:0] bump_base;
  logic              live_used  [TABLE_ENTRIES];
  logic [WORD_W-1:0] live_base  [TABLE_ENTRIES];
  logic [WORD_W-1:0] live_len   [TABLE_ENTRIES];
  logic              freed_used [TABLE_ENTRIES];
  logic [WORD_W-1:0] freed_base [TABLE_ENTRIES];
  logic [WORD_W-1:0] freed_len  [TABLE_ENTRIES];

  alloc_result_t expected_results [$];

  // live slot already holding addr, else first empty live slot, else -1
  function automatic int live_slot(logic [WORD_W-1:0] addr);
    int empty;
    int i;
    empty = -1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (live_used[i]) begin
        if (live_base[i] == addr) return i;
      end else if (empty < 0) begin
        empty = i;
      end
    end
    return empty;
  endfunction

  // apply one request to the shadow state and return the result it must give
  function automatic alloc_result_t serve_request(logic req_type, logic [WORD_W-1:0] size,
                                                  logic [WORD_W-1:0] addr);
    alloc_result_t res;
    logic [WORD_W:0] limit;
    int slot;
    int best;
    int hit;
    int same;
    int empty;
    int i;
    res = '0;
    res.status = STAT_OK;
    limit = (mem_size < MIN_MEMORY) ? {1'b0, MIN_MEMORY} : {1'b0, mem_size};
    if (req_type == REQ_ALLOC) begin
      if (size == '0) begin
        res.status = STAT_OK;
      end else if ({1'b0, size} > limit) begin
        res.status = STAT_NOSPACE;
      end else if ({1'b0, bump_base} + {1'b0, size} <= limit) begin
        // carve from the bump offset
        slot = live_slot(bump_base);
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          live_used[slot] = 1'b1;
          live_base[slot] = bump_base;
          live_len[slot]  = size;
          res.grant_addr  = bump_base;
          bump_base       = bump_base + size;
        end
      end else begin
        // best fit: smallest freed block that is large enough, lowest address on a tie
        best = -1;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (freed_used[i] && freed_len[i] >= size) begin
            if (best < 0 || freed_len[i] < freed_len[best] ||
                (freed_len[i] == freed_len[best] && freed_base[i] < freed_base[best]))
              best = i;
          end
        end
        if (best < 0) begin
          res.status = STAT_NOSPACE;
        end else begin
          slot = live_slot(freed_base[best]);
          if (slot < 0) begin
            res.status = STAT_FULL;
          end else begin
            freed_used[best] = 1'b0;
            live_used[slot]  = 1'b1;
            live_base[slot]  = freed_base[best];
            live_len[slot]   = size;
            res.grant_addr   = freed_base[best];
          end
        end
      end
    end else begin
      // free: first live entry at addr
      hit = -1;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0 && live_used[i] && live_base[i] == addr) hit = i;
      end
      if (hit < 0) begin
        res.status = STAT_UNKNOWN;
      end else begin
        same  = -1;
        empty = -1;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (freed_used[i]) begin
            if (same < 0 && freed_base[i] == addr) same = i;
          end else if (empty < 0) begin
            empty = i;
          end
        end
        slot = (same >= 0) ? same : empty;
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          res.freed_len    = live_len[hit];
          live_used[hit]   = 1'b0;
          freed_used[slot] = 1'b1;
          freed_base[slot] = addr;
          freed_len[slot]  = res.freed_len;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // watch config writes, accepted requests and accepted results
  always @(posedge clk) begin : watch
    alloc_result_t want;
    int i;
    if (!rst_n) begin
      mem_size  = MEM_SIZE_RESET;
      bump_base = '0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        live_used[i]  = 1'b0;
        freed_used[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) mem_size = cfg_wdata;
      // result side: compare with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", '0, out_status);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", want.status, out_status);
          if (out_result_address !== want.grant_addr)
            report_mismatch("result_address", want.grant_addr, out_result_address);
          if (out_freed_size !== want.freed_len)
            report_mismatch("freed_size", want.freed_len, out_freed_size);
        end
      end
      // request side: predict and queue
      if (in_valid && in_ready)
        expected_results.push_back(serve_request(in_req_type, in_req_size, in_req_address));
    end
    outstanding = expected_results.size();
  end

endmodule

### verif/tb_bump_best_fit_allocator.sv
// testbench top for the allocator: clock, reset, request stimulus, size settings and verdict
`timescale 1ns / 100ps

module tb_bump_best_fit_allocator import bbfa_pkg::*;;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned IDLE_PCT      = 35;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_req_type;
  logic [WORD_W-1:0] in_req_size;
  logic [WORD_W-1:0] in_req_address;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_result_address;
  logic [WORD_W-1:0] out_freed_size;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned alloc_count;
  int unsigned free_count;
  int unsigned size_settings;
  int unsigned status_seen [4];
  bit          steady;

  // addresses handed out by the block, candidates for later frees
  logic [WORD_W-1:0] granted [$];

  bump_best_fit_allocator #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_req_size        (in_req_size),
    .in_req_address     (in_req_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_freed_size     (out_freed_size),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  bbfa_alloc_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_req_size        (in_req_size),
    .in_req_address     (in_req_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_freed_size     (out_freed_size),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // clock
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run limit reached with %0d results outstanding", outstanding);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // collect granted addresses and tally outcomes
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      status_seen[out_status]++;
      if (out_status == STAT_OK && out_freed_size == '0) granted.push_back(out_result_address);
    end
  end

  // present one item and hold it until accepted
  task automatic push_request(logic req_type, logic [WORD_W-1:0] size, logic [WORD_W-1:0] addr);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_req_type    = req_type;
    in_req_size    = size;
    in_req_address = addr;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (req_type == REQ_ALLOC) alloc_count++;
    else free_count++;
  endtask

  // wait until the block is idle, then write the size register
  task automatic set_mem_size(logic [WORD_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0 || !in_ready) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    size_settings++;
  endtask

  // random mix of allocates and frees, frees mostly of granted addresses
  task automatic run_random(int count, int alloc_pct, logic [WORD_W-1:0] size_cap, bit wide);
    logic [WORD_W-1:0] sz;
    logic [WORD_W-1:0] ad;
    int idx;
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < alloc_pct) begin
        case ($urandom_range(9))
          0:       sz = wide ? $urandom : $urandom_range(size_cap, 1);
          1:       sz = '0;
          2, 3:    sz = 32'd8 << $urandom_range(2);
          default: sz = $urandom_range(size_cap, 1);
        endcase
        push_request(REQ_ALLOC, sz, $urandom);
      end else if (granted.size() != 0 && $urandom_range(7) != 0) begin
        idx = $urandom_range(granted.size() - 1);
        ad  = granted[idx];
        granted.delete(idx);
        push_request(REQ_FREE, $urandom, ad);
      end else begin
        push_request(REQ_FREE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_ALLOC;
    in_req_size    = '0;
    in_req_address = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    steady         = 1'b0;
    size_settings  = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero size, oversize, bump, frees, double free, best fit with a tie
    push_request(REQ_ALLOC, 32'd0, $urandom);
    push_request(REQ_ALLOC, 32'd16, $urandom);
    push_request(REQ_ALLOC, 32'd100, $urandom);
    push_request(REQ_ALLOC, 32'd8, $urandom);
    push_request(REQ_ALLOC, 32'd4097, $urandom);
    push_request(REQ_ALLOC, 32'hFFFF_FFFF, $urandom);
    push_request(REQ_FREE, $urandom, 32'd16);
    push_request(REQ_FREE, $urandom, 32'd0);
    push_request(REQ_FREE, $urandom, 32'd16);
    push_request(REQ_FREE, $urandom, 32'hFFFF_FFFF);
    push_request(REQ_ALLOC, 32'd3972, $urandom);
    push_request(REQ_ALLOC, 32'd1, $urandom);
    push_request(REQ_ALLOC, 32'd50, $urandom);
    push_request(REQ_ALLOC, 32'd1, $urandom);
    push_request(REQ_FREE, $urandom, 32'd124);
    push_request(REQ_ALLOC, 32'd8, $urandom);
    push_request(REQ_FREE, $urandom, 32'd124);
    push_request(REQ_FREE, $urandom, 32'd116);
    push_request(REQ_ALLOC, 32'd8, 32'd0);
    push_request(REQ_ALLOC, 32'd4096, $urandom);

    // size below the minimum, small blocks: bump runs out, best fit and no space
    set_mem_size(32'd0);
    run_random(120, 60, 32'd96, 1'b1);

    // largest size: fill the live table with no idling, then the freed table
    set_mem_size(32'hFFFF_FFFF);
    steady = 1'b1;
    run_random(90, 85, 32'd32, 1'b0);
    steady = 1'b0;
    run_random(100, 30, 32'd32, 1'b0);

    // just below the minimum, then a random mid-range size
    set_mem_size(32'd4095);
    run_random(50, 50, 32'd64, 1'b1);
    set_mem_size($urandom_range(32'h8000_0000, 32'd4096));
    run_random(60, 50, 32'd256, 1'b1);

    // drain
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2 * TABLE_ENTRIES + 8) @(negedge clk);

    $display("ran %0d requests (%0d allocates, %0d frees) over %0d memory size settings",
             items_sent, alloc_count, free_count, size_settings);
    $display("outcomes: %0d ok, %0d no space, %0d unknown address, %0d table full",
             status_seen[STAT_OK], status_seen[STAT_NOSPACE], status_seen[STAT_UNKNOWN],
             status_seen[STAT_FULL]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
